### rtl/core/sorted_key_table_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key table
// Shared shorthand for the concurrent checks on the table's ports.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_TOP_ASSERT_SVH
`define SORTED_KEY_TABLE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SKT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted key table: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SKT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted key table: next-cycle check failed");

`endif

### rtl/core/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Types, codes and widths shared by the sorted key table and its channels.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int DEPTH_DEF = 16;

	localparam int OP_W     = 2;
	localparam int KEY_W    = 32;
	localparam int TAG_W    = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_SHOW   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
	} entry_t;

endpackage

### rtl/core/skt_req_if.sv
// ----------------------------------------------------------------------------
// skt_req_if
// Request channel of the sorted key table: operation, key and tag.
// ----------------------------------------------------------------------------
interface skt_req_if;
	import skt_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         op;
	logic signed [KEY_W-1:0] key_value;
	logic [TAG_W-1:0]        tag_value;

	modport source (output valid, output op, output key_value, output tag_value,
		input ready);
	modport sink (input valid, input op, input key_value, input tag_value,
		output ready);
endinterface

### rtl/core/skt_rsp_if.sv
// ----------------------------------------------------------------------------
// skt_rsp_if
// Result channel of the sorted key table: status, shown entry and count.
// ----------------------------------------------------------------------------
interface skt_rsp_if;
	import skt_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic                    entry_valid;
	logic signed [KEY_W-1:0] entry_key;
	logic [TAG_W-1:0]        entry_tag;
	logic [COUNT_W-1:0]      entry_count;
	logic                    last;

	modport source (output valid, output status, output entry_valid, output entry_key,
		output entry_tag, output entry_count, output last, input ready);
	modport sink (input valid, input status, input entry_valid, input entry_key,
		input entry_tag, input entry_count, input last, output ready);
endinterface

### rtl/core/sorted_key_table_top.sv
// ----------------------------------------------------------------------------
// sorted_key_table_top
// Table of up to DEPTH key and tag entries, kept in ascending key order.
// ----------------------------------------------------------------------------
// The block takes one request at a time on req (insert, delete by key, show)
// and answers on rsp with valid/ready handshakes. Insert and delete give one
// result each; show gives one result per held entry, in key order, and marks
// the final one with last. A show of an empty table gives a single result
// with entry_valid low.
// The entries live in a single synchronous memory with a registered read.
// Insert walks down from the top entry, moving each larger entry up by one
// and then writing the new entry. Delete walks up from the bottom, moving
// the entries after the match down by one. Show streams one entry per cycle
// while rsp is ready. req.ready is high only while no request is in
// progress; a finished result waits in the output register, so a new
// request is taken while the receiver stalls. When rsp stalls during a
// show the walk pauses.
// Reset empties the table at once (the count returns to zero) and drops any
// pending result; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module sorted_key_table_top #(
	parameter int DEPTH = skt_pkg::DEPTH_DEF
) (
	input logic  clk,
	input logic  arst_n,
	skt_req_if.sink   req,
	skt_rsp_if.source rsp
);
	import skt_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_INS     = 3'd1;
	localparam logic [2:0] S_INS_FIN = 3'd2;
	localparam logic [2:0] S_DEL     = 3'd3;
	localparam logic [2:0] S_SHOW    = 3'd4;
	localparam logic [2:0] S_RES     = 3'd5;

	// Entry memory: one write and one registered read per cycle.
	entry_t mem [DEPTH];
	entry_t rd_data;

	logic [2:0]              state_q;
	logic [CW-1:0]           cnt_q;
	logic signed [KEY_W-1:0] key_q;
	logic [TAG_W-1:0]        tag_q;
	logic [AW-1:0]           rd_idx_q;
	logic                    rd_more_q;
	logic                    pend_s1;
	logic [AW-1:0]           idx_s1;
	logic                    found_q;
	logic [AW-1:0]           wpos_q;
	logic [STATUS_W-1:0]     res_status_q;

	logic                    out_valid_q;
	logic [STATUS_W-1:0]     out_status_q;
	logic                    out_entry_valid_q;
	logic signed [KEY_W-1:0] out_key_q;
	logic [TAG_W-1:0]        out_tag_q;
	logic [COUNT_W-1:0]      out_count_q;
	logic                    out_last_q;

	logic          out_free;
	logic          out_load;
	logic [AW-1:0] cnt_last;
	logic          last_e;
	logic          key_gt;
	logic          key_lt;
	logic          key_eq;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	entry_t        mem_wd;
	logic          mem_re;
	logic          consume;
	logic          scan_done;
	logic          scan_ok;
	logic          rd_down;
	logic [AW-1:0] rd_end;

	assign out_free = !out_valid_q || rsp.ready;
	assign cnt_last = AW'(cnt_q - 1'b1);
	assign last_e   = (idx_s1 == cnt_last);
	assign key_gt   = $signed(rd_data.key) > $signed(key_q);
	assign key_lt   = $signed(rd_data.key) < $signed(key_q);
	assign key_eq   = (rd_data.key == key_q);
	assign rd_down  = (state_q == S_INS);
	assign rd_end   = rd_down ? '0 : cnt_last;

	// A new result enters the output register in this cycle.
	assign out_load = (state_q == S_SHOW) ? consume : ((state_q == S_RES) && out_free);

	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_valid = out_entry_valid_q;
	assign rsp.entry_key   = out_key_q;
	assign rsp.entry_tag   = out_tag_q;
	assign rsp.entry_count = out_count_q;
	assign rsp.last        = out_last_q;

	// Decisions of the memory walk for the entry that has just been read.
	always_comb begin
		mem_we    = 1'b0;
		mem_wa    = idx_s1;
		mem_wd    = rd_data;
		mem_re    = 1'b0;
		consume   = 1'b0;
		scan_done = 1'b0;
		scan_ok   = 1'b0;
		case (state_q)
			S_INS: begin
				if (pend_s1) begin
					consume = 1'b1;
					if (key_gt) begin
						// Larger entry moves up to make room.
						mem_we = 1'b1;
						mem_wa = AW'(idx_s1 + 1'b1);
						if (idx_s1 == '0) begin
							scan_done = 1'b1;
						end
					end else begin
						scan_done = 1'b1;
					end
				end
				mem_re = rd_more_q && !scan_done;
			end
			S_INS_FIN: begin
				mem_we = 1'b1;
				mem_wa = wpos_q;
				mem_wd = '{key: key_q, tag: tag_q};
			end
			S_DEL: begin
				if (pend_s1) begin
					consume = 1'b1;
					if (found_q) begin
						// Entries after the match close the gap.
						mem_we = 1'b1;
						mem_wa = AW'(idx_s1 - 1'b1);
						if (last_e) begin
							scan_done = 1'b1;
							scan_ok   = 1'b1;
						end
					end else if (key_lt) begin
						scan_done = last_e;
					end else if (key_eq) begin
						scan_done = last_e;
						scan_ok   = last_e;
					end else begin
						scan_done = 1'b1;
					end
				end
				mem_re = rd_more_q && !scan_done;
			end
			S_SHOW: begin
				consume = pend_s1 && out_free;
				mem_re  = rd_more_q && (!pend_s1 || out_free);
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data <= mem[rd_idx_q];
		end
	end

	// Request payload and walk bookkeeping carry no reset.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			key_q <= req.key_value;
			tag_q <= req.tag_value;
		end
		if (state_q == S_INS && scan_done) begin
			wpos_q <= key_gt ? '0 : AW'(idx_s1 + 1'b1);
		end else if (state_q == S_IDLE) begin
			wpos_q <= '0;
		end
		if (mem_re) begin
			idx_s1 <= rd_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			cnt_q             <= '0;
			rd_idx_q          <= '0;
			rd_more_q         <= 1'b0;
			pend_s1           <= 1'b0;
			found_q           <= 1'b0;
			res_status_q      <= ST_OK;
			out_valid_q       <= 1'b0;
			out_status_q      <= ST_OK;
			out_entry_valid_q <= 1'b0;
			out_key_q         <= '0;
			out_tag_q         <= '0;
			out_count_q       <= '0;
			out_last_q        <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			// Read pointer of the walk, shared by all three operations.
			if (mem_re) begin
				pend_s1   <= 1'b1;
				rd_more_q <= (rd_idx_q != rd_end);
				rd_idx_q  <= rd_down ? AW'(rd_idx_q - 1'b1) : AW'(rd_idx_q + 1'b1);
			end else if (consume || state_q == S_IDLE) begin
				pend_s1 <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						found_q   <= 1'b0;
						rd_more_q <= 1'b1;
						case (req.op)
							OP_INSERT: begin
								if (cnt_q == CW'(DEPTH)) begin
									res_status_q <= ST_FULL;
									state_q      <= S_RES;
								end else if (cnt_q == '0) begin
									state_q <= S_INS_FIN;
								end else begin
									rd_idx_q <= cnt_last;
									state_q  <= S_INS;
								end
							end
							OP_DELETE: begin
								rd_idx_q <= '0;
								if (cnt_q == '0) begin
									res_status_q <= ST_EMPTY;
									state_q      <= S_RES;
								end else begin
									state_q <= S_DEL;
								end
							end
							OP_SHOW: begin
								rd_idx_q <= '0;
								if (cnt_q == '0) begin
									res_status_q <= ST_OK;
									state_q      <= S_RES;
								end else begin
									state_q <= S_SHOW;
								end
							end
							default: begin
								res_status_q <= ST_OK;
								state_q      <= S_RES;
							end
						endcase
					end
				end
				S_INS: begin
					if (scan_done) begin
						state_q <= S_INS_FIN;
					end
				end
				S_INS_FIN: begin
					cnt_q        <= CW'(cnt_q + 1'b1);
					res_status_q <= ST_OK;
					state_q      <= S_RES;
				end
				S_DEL: begin
					if (pend_s1 && !found_q && key_eq) begin
						found_q <= 1'b1;
					end
					if (scan_done) begin
						if (scan_ok) begin
							cnt_q        <= CW'(cnt_q - 1'b1);
							res_status_q <= ST_OK;
						end else begin
							res_status_q <= ST_NOT_FOUND;
						end
						state_q <= S_RES;
					end
				end
				S_SHOW: begin
					if (consume) begin
						out_status_q      <= ST_OK;
						out_entry_valid_q <= 1'b1;
						out_key_q         <= rd_data.key;
						out_tag_q         <= rd_data.tag;
						out_count_q       <= COUNT_W'(cnt_q);
						out_last_q        <= last_e;
						if (last_e) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RES: begin
					if (out_free) begin
						out_status_q      <= res_status_q;
						out_entry_valid_q <= 1'b0;
						out_key_q         <= '0;
						out_tag_q         <= '0;
						out_count_q       <= COUNT_W'(cnt_q);
						out_last_q        <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/core/skt_checker.sv
// ----------------------------------------------------------------------------
// skt_checker
// Port-level checks on the sorted key table, bound to its top level.
// ----------------------------------------------------------------------------
`include "sorted_key_table_top_assert.svh"

module skt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_ready,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic [skt_pkg::STATUS_W-1:0]    rsp_status,
	input logic                            rsp_entry_valid,
	input logic signed [skt_pkg::KEY_W-1:0] rsp_entry_key,
	input logic [skt_pkg::TAG_W-1:0]       rsp_entry_tag,
	input logic                            rsp_last
);
	import skt_pkg::*;

	// A result held back by the receiver stays valid and keeps its key, tag and last flag.
	`SKT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_entry_key) && $stable(rsp_entry_tag) && $stable(rsp_last))

	// Only one request is in progress at a time.
	`SKT_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

	// A shown entry always comes with an ok status.
	`SKT_ASSERT_SAME(a_shown_ok, rsp_valid && rsp_entry_valid, rsp_status == ST_OK)

	// A result without an entry is the only result of its request.
	`SKT_ASSERT_SAME(a_plain_last, rsp_valid && !rsp_entry_valid, rsp_last)

endmodule

bind sorted_key_table_top skt_checker u_skt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_entry_valid (rsp.entry_valid),
	.rsp_entry_key   (rsp.entry_key),
	.rsp_entry_tag   (rsp.entry_tag),
	.rsp_last        (rsp.last)
);
